// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define LJ_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define LJ_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/ljpe_pkg.sv =====
`timescale 1ns / 1ps
package ljpe_pkg;

  localparam int AXIS_W  = 2;
  localparam int ENTRY_W = 192;

  localparam logic [63:0] POS_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ENERGY_SCALE = 64'd4;
  localparam logic [63:0] FORCE_SCALE  = 64'd24;

  localparam logic OPER_WRITE = 1'b0;
  localparam logic OPER_PAIR  = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISPATCH,
    ST_SQ_GO, ST_SQ_RUN, ST_SQ_ADD,
    ST_CSQ_GO, ST_CSQ_RUN, ST_CSQ_SET,
    ST_CHECK,
    ST_Q_GO, ST_Q_RUN, ST_QQ_GO, ST_QQ_RUN,
    ST_S6_GO, ST_S6_RUN, ST_S12_GO, ST_S12_RUN, ST_S12_SET,
    ST_DIFF, ST_SHSUB,
    ST_E_GO, ST_E_RUN, ST_E_SGN, ST_E_ADD,
    ST_G, ST_F_GO, ST_F_RUN, ST_F_SET,
    ST_FD_GO, ST_FD_RUN, ST_FQ_GO, ST_FQ_RUN, ST_FQ_SGN, ST_F_ADD,
    ST_WR, ST_FINISH
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE,
    OP_SQ_GO, OP_SQ_ADD, OP_CSQ_GO, OP_CSQ_SET, OP_CHECK,
    OP_Q_GO, OP_QQ_GO, OP_S6_GO, OP_S12_GO, OP_S12_SET,
    OP_DIFF, OP_SHSUB, OP_E_GO, OP_E_SGN, OP_E_ADD,
    OP_G, OP_F_GO, OP_F_SET, OP_FD_GO, OP_FQ_GO, OP_FQ_SGN, OP_F_ADD,
    OP_WR, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic is_pair;
    logic types_ok;
    logic den_zero;
    logic in_cutoff;
    logic want_force;
    logic last_pair;
    logic mul_last;
    logic div_last;
    logic axis_last;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== hw/rtl/ljpe_ram.sv =====
`timescale 1ns / 1ps
module ljpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ljpe_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ljpe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ljpe_pkg::dp_sts_t sts,
  output ljpe_pkg::dp_op_t  op
);
  import ljpe_pkg::*;

  ctl_state_t state, state_next;
  logic       accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        if (sts.is_pair) state_next = ST_SQ_GO;
        else if (sts.types_ok) state_next = ST_CSQ_GO;
        else state_next = ST_IDLE;
      end
      ST_SQ_GO:    state_next = ST_SQ_RUN;
      ST_SQ_RUN:   if (sts.mul_last) state_next = ST_SQ_ADD;
      ST_SQ_ADD:   state_next = sts.axis_last ? ST_CHECK : ST_SQ_GO;
      ST_CSQ_GO:   state_next = ST_CSQ_RUN;
      ST_CSQ_RUN:  if (sts.mul_last) state_next = ST_CSQ_SET;
      ST_CSQ_SET:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (sts.den_zero) state_next = sts.is_pair ? ST_FINISH : ST_WR;
        else if (!sts.is_pair) state_next = ST_Q_GO;
        else if (sts.types_ok && sts.in_cutoff) state_next = ST_Q_GO;
        else state_next = ST_FINISH;
      end
      ST_Q_GO:     state_next = ST_Q_RUN;
      ST_Q_RUN:    if (sts.div_last) state_next = ST_QQ_GO;
      ST_QQ_GO:    state_next = ST_QQ_RUN;
      ST_QQ_RUN:   if (sts.mul_last) state_next = ST_S6_GO;
      ST_S6_GO:    state_next = ST_S6_RUN;
      ST_S6_RUN:   if (sts.mul_last) state_next = ST_S12_GO;
      ST_S12_GO:   state_next = ST_S12_RUN;
      ST_S12_RUN:  if (sts.mul_last) state_next = ST_S12_SET;
      ST_S12_SET:  state_next = ST_DIFF;
      ST_DIFF:     state_next = sts.is_pair ? ST_SHSUB : ST_WR;
      ST_SHSUB:    state_next = ST_E_GO;
      ST_E_GO:     state_next = ST_E_RUN;
      ST_E_RUN:    if (sts.mul_last) state_next = ST_E_SGN;
      ST_E_SGN:    state_next = ST_E_ADD;
      ST_E_ADD:    state_next = sts.want_force ? ST_G : ST_FINISH;
      ST_G:        state_next = ST_F_GO;
      ST_F_GO:     state_next = ST_F_RUN;
      ST_F_RUN:    if (sts.mul_last) state_next = ST_F_SET;
      ST_F_SET:    state_next = ST_FD_GO;
      ST_FD_GO:    state_next = ST_FD_RUN;
      ST_FD_RUN:   if (sts.mul_last) state_next = ST_FQ_GO;
      ST_FQ_GO:    state_next = ST_FQ_RUN;
      ST_FQ_RUN:   if (sts.div_last) state_next = ST_FQ_SGN;
      ST_FQ_SGN:   state_next = ST_F_ADD;
      ST_F_ADD:    state_next = sts.axis_last ? ST_FINISH : ST_FD_GO;
      ST_WR:       state_next = ST_IDLE;
      ST_FINISH:   if (!(sts.last_pair && sts.out_busy)) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    unique case (state)
      ST_IDLE:    op = accept ? OP_CAPTURE : OP_NONE;
      ST_SQ_GO:   op = OP_SQ_GO;
      ST_SQ_ADD:  op = OP_SQ_ADD;
      ST_CSQ_GO:  op = OP_CSQ_GO;
      ST_CSQ_SET: op = OP_CSQ_SET;
      ST_CHECK:   op = OP_CHECK;
      ST_Q_GO:    op = OP_Q_GO;
      ST_QQ_GO:   op = OP_QQ_GO;
      ST_S6_GO:   op = OP_S6_GO;
      ST_S12_GO:  op = OP_S12_GO;
      ST_S12_SET: op = OP_S12_SET;
      ST_DIFF:    op = OP_DIFF;
      ST_SHSUB:   op = OP_SHSUB;
      ST_E_GO:    op = OP_E_GO;
      ST_E_SGN:   op = OP_E_SGN;
      ST_E_ADD:   op = OP_E_ADD;
      ST_G:       op = OP_G;
      ST_F_GO:    op = OP_F_GO;
      ST_F_SET:   op = OP_F_SET;
      ST_FD_GO:   op = OP_FD_GO;
      ST_FQ_GO:   op = OP_FQ_GO;
      ST_FQ_SGN:  op = OP_FQ_SGN;
      ST_F_ADD:   op = OP_F_ADD;
      ST_WR:      op = OP_WR;
      ST_FINISH:  op = (sts.last_pair && sts.out_busy) ? OP_NONE : OP_EMIT;
      default:    op = OP_NONE;
    endcase
  end

  `LJ_NEXT(accept_goes_dispatch, accept, state == ST_DISPATCH)
  `LJ_NEXT(div_wait_holds, (state == ST_Q_RUN || state == ST_FQ_RUN) && !sts.div_last, $stable(state))
  `LJ_NEXT(emit_blocked_holds, state == ST_FINISH && sts.last_pair && sts.out_busy, state == ST_FINISH)

endmodule

// ===== hw/rtl/ljpe_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ljpe_dp #(
  parameter int NUM_TYPES = 4,
  parameter int NUM_DIMS  = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  ljpe_pkg::dp_op_t   op,
  output ljpe_pkg::dp_sts_t  sts,
  input  logic               operation,
  input  logic [1:0]         type_a,
  input  logic [1:0]         type_b,
  input  logic signed [31:0] dx,
  input  logic signed [31:0] dy,
  input  logic signed [31:0] dz,
  input  logic [31:0]        sigma_sq,
  input  logic [31:0]        well_depth,
  input  logic [31:0]        cutoff,
  input  logic               want_force,
  input  logic               last_pair,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] energy_sum,
  output logic signed [63:0] force_x,
  output logic signed [63:0] force_y,
  output logic signed [63:0] force_z,
  output logic               saturated
);
  import ljpe_pkg::*;

  localparam int TBL_DEPTH = NUM_TYPES * NUM_TYPES;
  localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return {1'b1, (s[64] ? NEG_MIN : POS_MAX)};
    return {1'b0, s[63:0]};
  endfunction

  function automatic logic [64:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return {1'b1, (s[64] ? NEG_MIN : POS_MAX)};
    return {1'b0, s[63:0]};
  endfunction

  // captured item
  logic               oper_r, wf_r, last_r;
  logic [1:0]         ta_r, tb_r;
  logic signed [31:0] d_r [3];
  logic [31:0]        sig_r, eps_r, cut_r;
  logic [IDX_W-1:0]   idx_r, idx_next;
  logic [1:0]         t_lo, t_hi;

  // working registers
  logic [AXIS_W-1:0]  axis;
  logic [63:0]        den, qv, s6, s12, wk, term;
  logic               sgn;

  // accumulators and result
  logic [63:0]        energy_acc;
  logic [63:0]        force_acc [3];
  logic               sat_flag;
  logic [63:0]        out_e, out_sat_unused_guard;
  logic [63:0]        out_f [3];
  logic               out_sat;

  // shared multiplier, four 32x32 passes
  logic [63:0]  ma, mb, preg, ma_in, mb_in, part_prod;
  logic [31:0]  pa, pb;
  logic [127:0] macc, addend;
  logic [2:0]   mcnt;
  logic         mbusy, mul_go, mul_last;

  // shared divider, one quotient bit a cycle
  logic [63:0]  dr, dlo, dd, dq, dd_in;
  logic [127:0] dn_in;
  logic [64:0]  rr;
  logic [5:0]   dcnt;
  logic         dbusy, dsat, div_go, div_last, qbit;

  // table
  logic [ENTRY_W-1:0] rd;
  logic [31:0]        r_sig, r_eps;
  logic [63:0]        r_csq, r_shift;

  // derived values
  logic signed [31:0] d_sel;
  logic [31:0]        d_mag, sig_src;
  logic [63:0]        qm_res, s24_res, div_res, wk_mag, two, gm;
  logic               qm_sat, s24_sat, div_sat, g_sat, is_pair, sat_hit;
  logic [64:0]        shsub, eadd, fadd;

  assign out_sat_unused_guard = out_e;

  ljpe_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_ram (
    .clk  (clk),
    .we   (op == OP_WR),
    .waddr(idx_r),
    .wdata({sig_r, eps_r, den, wk}),
    .raddr(idx_r),
    .rdata(rd)
  );

  assign r_sig   = rd[191:160];
  assign r_eps   = rd[159:128];
  assign r_csq   = rd[127:64];
  assign r_shift = rd[63:0];

  always_comb begin
    t_lo     = (type_a < type_b) ? type_a : type_b;
    t_hi     = (type_a < type_b) ? type_b : type_a;
    idx_next = IDX_W'(int'(t_lo) * NUM_TYPES + int'(t_hi));
  end

  assign is_pair = (oper_r == OPER_PAIR);
  assign d_sel   = d_r[axis];
  assign d_mag   = d_sel[31] ? 32'(-d_sel) : 32'(d_sel);
  assign sig_src = is_pair ? r_sig : sig_r;
  assign wk_mag  = wk[63] ? -wk : wk;

  assign qm_sat  = |macc[127:95];
  assign qm_res  = qm_sat ? POS_MAX : macc[95:32];
  assign s24_sat = |macc[127:87];
  assign s24_res = s24_sat ? POS_MAX : macc[87:24];
  assign div_sat = dsat || dq[63];
  assign div_res = div_sat ? POS_MAX : dq;

  assign two   = {s6[62:0], 1'b0};
  assign gm    = two - s12;
  assign g_sat = (two >= s12) && gm[63];

  assign shsub = sat_sub(wk, r_shift);
  assign eadd  = sat_add(energy_acc, wk);
  assign fadd  = sat_add(force_acc[axis], term);

  // multiplier operands and pass control
  always_comb begin
    mul_go = 1'b0;
    ma_in  = '0;
    mb_in  = '0;
    case (op)
      OP_SQ_GO:  begin mul_go = 1'b1; ma_in = {32'b0, d_mag}; mb_in = {32'b0, d_mag}; end
      OP_CSQ_GO: begin mul_go = 1'b1; ma_in = {32'b0, cut_r}; mb_in = {32'b0, cut_r}; end
      OP_QQ_GO:  begin mul_go = 1'b1; ma_in = div_res; mb_in = div_res; end
      OP_S6_GO:  begin mul_go = 1'b1; ma_in = qm_res; mb_in = qv; end
      OP_S12_GO: begin mul_go = 1'b1; ma_in = qm_res; mb_in = qm_res; end
      OP_E_GO:   begin mul_go = 1'b1; ma_in = wk_mag; mb_in = {32'b0, r_eps} * ENERGY_SCALE; end
      OP_F_GO:   begin mul_go = 1'b1; ma_in = wk; mb_in = {32'b0, r_eps} * FORCE_SCALE; end
      OP_FD_GO:  begin mul_go = 1'b1; ma_in = wk; mb_in = {32'b0, d_mag}; end
      default:   mul_go = 1'b0;
    endcase
  end

  assign pa        = mcnt[1] ? ma[63:32] : ma[31:0];
  assign pb        = mcnt[0] ? mb[63:32] : mb[31:0];
  assign part_prod = pa * pb;
  assign mul_last  = mbusy && (mcnt == 3'd4);

  always_comb begin
    case (mcnt)
      3'd1:         addend = {64'b0, preg};
      3'd2, 3'd3:   addend = {32'b0, preg, 32'b0};
      3'd4:         addend = {preg, 64'b0};
      default:      addend = '0;
    endcase
  end

  // divider operands
  always_comb begin
    div_go = 1'b0;
    dn_in  = '0;
    dd_in  = den;
    case (op)
      OP_Q_GO:  begin div_go = 1'b1; dn_in = {40'b0, sig_src, 56'b0}; end
      OP_FQ_GO: begin div_go = 1'b1; dn_in = {macc[103:0], 24'b0}; end
      default:  div_go = 1'b0;
    endcase
  end

  assign rr       = {dr, dlo[63]};
  assign qbit     = (rr >= {1'b0, dd});
  assign div_last = dbusy && (dcnt == 6'd63);

  always_comb begin
    case (op)
      OP_CHECK:                          sat_hit = (den == 64'd0);
      OP_QQ_GO, OP_FQ_SGN:               sat_hit = div_sat;
      OP_S6_GO, OP_S12_GO, OP_S12_SET:   sat_hit = qm_sat;
      OP_SHSUB:                          sat_hit = shsub[64];
      OP_E_SGN, OP_F_SET:                sat_hit = s24_sat;
      OP_E_ADD:                          sat_hit = eadd[64];
      OP_G:                              sat_hit = g_sat;
      OP_F_ADD:                          sat_hit = fadd[64];
      default:                           sat_hit = 1'b0;
    endcase
  end

  // control state and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy      <= 1'b0;
      dbusy      <= 1'b0;
      out_valid  <= 1'b0;
      energy_acc <= '0;
      force_acc  <= '{default: '0};
      sat_flag   <= 1'b0;
    end else begin
      if (mul_go) mbusy <= 1'b1;
      else if (mul_last) mbusy <= 1'b0;
      if (div_go) dbusy <= 1'b1;
      else if (div_last) dbusy <= 1'b0;

      if (is_pair && sat_hit) sat_flag <= 1'b1;
      if (op == OP_E_ADD) energy_acc <= eadd[63:0];
      if (op == OP_F_ADD) force_acc[axis] <= fadd[63:0];

      if (op == OP_EMIT && last_r) begin
        out_valid  <= 1'b1;
        energy_acc <= '0;
        force_acc  <= '{default: '0};
        sat_flag   <= 1'b0;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (op == OP_CAPTURE) begin
      oper_r <= operation;
      ta_r   <= type_a;
      tb_r   <= type_b;
      d_r[0] <= dx;
      d_r[1] <= dy;
      d_r[2] <= dz;
      sig_r  <= sigma_sq;
      eps_r  <= well_depth;
      cut_r  <= cutoff;
      wf_r   <= want_force;
      last_r <= last_pair;
      idx_r  <= idx_next;
      axis   <= '0;
      den    <= '0;
    end

    case (op)
      OP_SQ_ADD: begin
        den  <= den + macc[63:0];
        axis <= axis + 1'b1;
      end
      OP_CSQ_SET: den <= macc[63:0];
      OP_CHECK:   wk <= '0;
      OP_QQ_GO:   qv <= div_res;
      OP_S12_GO:  s6 <= qm_res;
      OP_S12_SET: s12 <= qm_res;
      OP_DIFF:    wk <= s12 - s6;
      OP_SHSUB:   wk <= shsub[63:0];
      OP_E_GO:    sgn <= wk[63];
      OP_E_SGN:   wk <= sgn ? -s24_res : s24_res;
      OP_G: begin
        if (two >= s12) begin
          wk  <= gm[63] ? POS_MAX : gm;
          sgn <= 1'b0;
        end else begin
          wk  <= s12 - two;
          sgn <= 1'b1;
        end
      end
      OP_F_SET: begin
        wk   <= s24_res;
        axis <= '0;
      end
      OP_FQ_SGN:  term <= (sgn ^ d_sel[31]) ? -div_res : div_res;
      OP_F_ADD:   axis <= axis + 1'b1;
      OP_EMIT: begin
        if (last_r) begin
          out_e    <= energy_acc;
          out_f[0] <= force_acc[0];
          out_f[1] <= force_acc[1];
          out_f[2] <= force_acc[2];
          out_sat  <= sat_flag;
        end
      end
      default: ;
    endcase

    if (mul_go) begin
      ma   <= ma_in;
      mb   <= mb_in;
      mcnt <= '0;
      macc <= '0;
    end else if (mbusy) begin
      preg <= part_prod;
      macc <= macc + addend;
      mcnt <= mcnt + 1'b1;
    end

    if (div_go) begin
      dr   <= dn_in[127:64];
      dlo  <= dn_in[63:0];
      dd   <= dd_in;
      dq   <= '0;
      dcnt <= '0;
      dsat <= (dd_in == 64'd0) || (dn_in[127:64] >= dd_in);
    end else if (dbusy) begin
      if (qbit) dr <= 64'(rr - {1'b0, dd});
      else dr <= rr[63:0];
      dlo  <= {dlo[62:0], 1'b0};
      dq   <= {dq[62:0], qbit};
      dcnt <= dcnt + 1'b1;
    end
  end

  always_comb begin
    sts.is_pair    = is_pair;
    sts.types_ok   = (int'(ta_r) < NUM_TYPES) && (int'(tb_r) < NUM_TYPES);
    sts.den_zero   = (den == 64'd0);
    sts.in_cutoff  = (den < r_csq);
    sts.want_force = wf_r;
    sts.last_pair  = last_r;
    sts.mul_last   = mul_last;
    sts.div_last   = div_last;
    sts.axis_last  = (axis == AXIS_W'(NUM_DIMS - 1));
    sts.out_busy   = out_valid && out_stall;
  end

  assign energy_sum = out_sat_unused_guard;
  assign force_x    = out_f[0];
  assign force_y    = out_f[1];
  assign force_z    = out_f[2];
  assign saturated  = out_sat;

  `LJ_ALWAYS(units_exclusive, !(mbusy && dbusy))
  `LJ_NEXT(emit_clears_sums, op == OP_EMIT && last_r, energy_acc == 64'd0 && !sat_flag)

endmodule

// ===== hw/rtl/lj_pair_energy_force_accumulator.sv =====
`timescale 1ns / 1ps
// Lennard-Jones pair energy and force accumulator, truncated and shifted.
// Input channel (in_valid / in_stall): operation 0 writes the parameter entry
// for a type pair (sigma squared, epsilon, cutoff); operation 1 adds one pair
// displacement to the running energy and, with want_force, force sums.
// Output channel (out_valid / out_stall): one item on each pair with last_pair,
// carrying the Q32.32 sums and the saturated flag; the sums then clear.
// One item is worked on at a time; in_stall is high from acceptance until done.
// Work per item, done on the 64-step bit-serial divider and the shared
// multiplier (four 32x32 passes per product):
//   pair outside cutoff or zero distance: one squaring per axis
//   pair inside cutoff, no force: as above, plus one divide and four products
//   with force as well: one product, and per axis a product and a divide
//   table write: cutoff squared, then if nonzero one divide, three products
// The result sits in an output register; new items are taken while it waits.
// A finishing last pair waits only if that register is still stalled.
// Synchronous reset clears the sums, the flag and all handshake state; table
// entries hold nothing useful until written.
module lj_pair_energy_force_accumulator #(
  parameter int NUM_TYPES = 4,
  parameter int NUM_DIMS  = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic [1:0]         type_a,
  input  logic [1:0]         type_b,
  input  logic signed [31:0] dx,
  input  logic signed [31:0] dy,
  input  logic signed [31:0] dz,
  input  logic [31:0]        sigma_sq,
  input  logic [31:0]        well_depth,
  input  logic [31:0]        cutoff,
  input  logic               want_force,
  input  logic               last_pair,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] energy_sum,
  output logic signed [63:0] force_x,
  output logic signed [63:0] force_y,
  output logic signed [63:0] force_z,
  output logic               saturated
);
  import ljpe_pkg::*;

  dp_op_t  op;
  dp_sts_t sts;

  ljpe_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .op      (op)
  );

  ljpe_dp #(.NUM_TYPES(NUM_TYPES), .NUM_DIMS(NUM_DIMS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .sts       (sts),
    .operation (operation),
    .type_a    (type_a),
    .type_b    (type_b),
    .dx        (dx),
    .dy        (dy),
    .dz        (dz),
    .sigma_sq  (sigma_sq),
    .well_depth(well_depth),
    .cutoff    (cutoff),
    .want_force(want_force),
    .last_pair (last_pair),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .energy_sum(energy_sum),
    .force_x   (force_x),
    .force_y   (force_y),
    .force_z   (force_z),
    .saturated (saturated)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ljpe_pkg::*;

  localparam int NTYPES = 4;
  localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic        op;
    logic [1:0]  ta;
    logic [1:0]  tb;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [31:0] sig;
    logic [31:0] eps;
    logic [31:0] rc;
    logic        frc;
    logic        lst;
  } item_t;

  typedef struct {
    logic [63:0] e;
    logic [63:0] fx;
    logic [63:0] fy;
    logic [63:0] fz;
    logic        sat;
  } sums_t;

  typedef struct {
    item_t it;
    bit    typed;
    sums_t want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic operation = 0;
  logic [1:0] type_a = 0, type_b = 0;
  logic signed [31:0] dx = 0, dy = 0, dz = 0;
  logic [31:0] sigma_sq = 0, well_depth = 0, cutoff = 0;
  logic want_force = 0, last_pair = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [63:0] energy_sum, force_x, force_y, force_z;
  logic saturated;

  lj_pair_energy_force_accumulator u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .type_a(type_a), .type_b(type_b),
    .dx(dx), .dy(dy), .dz(dz), .sigma_sq(sigma_sq), .well_depth(well_depth),
    .cutoff(cutoff), .want_force(want_force), .last_pair(last_pair),
    .out_valid(out_valid), .out_stall(out_stall), .energy_sum(energy_sum),
    .force_x(force_x), .force_y(force_y), .force_z(force_z), .saturated(saturated)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  logic [31:0] sig_tab [16];
  logic [31:0] eps_tab [16];
  logic [63:0] rc2_tab [16];
  logic signed [63:0] shift_tab [16];
  logic signed [63:0] energy_run;
  logic signed [63:0] force_run [3];
  bit sat_run;
  bit clip;

  sums_t pending_sums [$];
  int errors = 0;
  int n_items = 0, n_sums = 0, n_writes = 0;
  bit calm = 0;

  function automatic logic [63:0] wide_div(logic [127:0] num, logic [63:0] den);
    logic [127:0] q;
    if (den == 0 || num[127:64] >= den) begin
      clip = 1;
      return MAXPOS;
    end
    q = num / {64'd0, den};
    if (q[63:0] > MAXPOS) begin
      clip = 1;
      return MAXPOS;
    end
    return q[63:0];
  endfunction

  function automatic logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:95] != 0) begin
      clip = 1;
      return MAXPOS;
    end
    return p[95:32];
  endfunction

  function automatic logic signed [63:0] scale_q24(logic signed [63:0] x, logic [63:0] f);
    logic [63:0] mag, r;
    logic [127:0] p;
    mag = x[63] ? -x : x;
    p = {64'd0, mag} * {64'd0, f};
    if (p[127:87] != 0) begin
      clip = 1;
      r = MAXPOS;
    end else begin
      r = p[87:24];
    end
    return x[63] ? -r : r;
  endfunction

  function automatic logic signed [63:0] add_clamp(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t > $signed({1'b0, MAXPOS})) begin
      clip = 1;
      return MAXPOS;
    end
    if (t < -$signed({1'b0, MAXPOS}) - 1) begin
      clip = 1;
      return {1'b1, 63'd0};
    end
    return t[63:0];
  endfunction

  function automatic logic [63:0] sixth_power(logic [31:0] s, logic [63:0] len2);
    logic [63:0] q;
    q = wide_div({64'd0, s, 32'd0} << 24, len2);
    return fix_mul(fix_mul(q, q), q);
  endfunction

  function automatic bit apply_item(item_t it, output sums_t r);
    logic [63:0] rsq, s6, s12, two, m, fm, dm, c;
    logic [63:0] mags [3];
    logic signed [63:0] d [3];
    logic signed [63:0] diff, e, g, f, term;
    logic [127:0] p;
    int idx;
    idx = it.ta * NTYPES + it.tb;
    if (it.op == OPER_WRITE) begin
      rsq = {32'd0, it.rc} * {32'd0, it.rc};
      diff = 0;
      if (rsq != 0) begin
        s6 = sixth_power(it.sig, rsq);
        s12 = fix_mul(s6, s6);
        diff = s12 - s6;
      end
      sig_tab[idx] = it.sig; sig_tab[it.tb * NTYPES + it.ta] = it.sig;
      eps_tab[idx] = it.eps; eps_tab[it.tb * NTYPES + it.ta] = it.eps;
      rc2_tab[idx] = rsq; rc2_tab[it.tb * NTYPES + it.ta] = rsq;
      shift_tab[idx] = diff; shift_tab[it.tb * NTYPES + it.ta] = diff;
      return 0;
    end
    d[0] = {{32{it.dx[31]}}, it.dx};
    d[1] = {{32{it.dy[31]}}, it.dy};
    d[2] = {{32{it.dz[31]}}, it.dz};
    rsq = 0;
    for (int k = 0; k < 3; k++) begin
      mags[k] = d[k][63] ? -d[k] : d[k];
      rsq = rsq + mags[k] * mags[k];
    end
    if (rsq == 0) begin
      sat_run = 1;
    end else if (rsq < rc2_tab[idx]) begin
      clip = 0;
      s6 = sixth_power(sig_tab[idx], rsq);
      s12 = fix_mul(s6, s6);
      diff = add_clamp(s12 - s6, -shift_tab[idx]);
      if (shift_tab[idx] == {1'b1, 63'd0}) diff = add_clamp(add_clamp(s12 - s6, MAXPOS), 1);
      e = scale_q24(diff, {32'd0, eps_tab[idx]} << 2);
      energy_run = add_clamp(energy_run, e);
      if (it.frc) begin
        two = s6 << 1;
        if (two >= s12) begin
          m = two - s12;
          if (m > MAXPOS) begin
            clip = 1;
            m = MAXPOS;
          end
          g = m;
        end else begin
          g = -(s12 - two);
        end
        f = scale_q24(g, {32'd0, eps_tab[idx]} * 64'd24);
        for (int k = 0; k < 3; k++) begin
          fm = f[63] ? -f : f;
          dm = mags[k];
          p = ({64'd0, fm} * {64'd0, dm}) << 24;
          c = wide_div(p, rsq);
          term = (f[63] != d[k][63]) ? -c : c;
          force_run[k] = add_clamp(force_run[k], term);
        end
      end
      if (clip) sat_run = 1;
    end
    if (!it.lst) return 0;
    r.e = energy_run; r.fx = force_run[0]; r.fy = force_run[1]; r.fz = force_run[2];
    r.sat = sat_run;
    energy_run = 0;
    force_run[0] = 0; force_run[1] = 0; force_run[2] = 0;
    sat_run = 0;
    return 1;
  endfunction

  task automatic send_item(item_t it, bit typed, sums_t want);
    sums_t r;
    if (!calm && $urandom_range(99) < 18) begin
      in_valid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1;
    operation <= it.op; type_a <= it.ta; type_b <= it.tb;
    dx <= it.dx; dy <= it.dy; dz <= it.dz;
    sigma_sq <= it.sig; well_depth <= it.eps; cutoff <= it.rc;
    want_force <= it.frc; last_pair <= it.lst;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    n_items++;
    if (it.op == OPER_WRITE) n_writes++;
    if (apply_item(it, r)) pending_sums.push_back(typed ? want : r);
  endtask

  function automatic item_t pair_item(logic [1:0] a, logic [1:0] b, logic [31:0] x,
                                      logic [31:0] y, logic [31:0] z, logic frc, logic lst);
    item_t it;
    it = '{OPER_PAIR, a, b, x, y, z, $urandom, $urandom, $urandom, frc, lst};
    return it;
  endfunction

  function automatic item_t write_item(logic [1:0] a, logic [1:0] b, logic [31:0] s,
                                       logic [31:0] ep, logic [31:0] rc);
    item_t it;
    it = '{OPER_WRITE, a, b, $urandom, $urandom, $urandom, s, ep, rc, $urandom, $urandom};
    return it;
  endfunction

  function automatic logic [31:0] rand_axis();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom_range(1) ? $urandom_range(32'h0300_0000)
                                        : -$urandom_range(32'h0300_0000);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst || calm) out_stall <= 0;
    else out_stall <= ($urandom_range(99) < 18);
  end

  always @(negedge clk) begin
    sums_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        errors++;
        $display("%0t: unexpected result e=%h", $time, energy_sum);
      end else begin
        w = pending_sums.pop_front();
        n_sums++;
        if (energy_sum !== w.e) begin
          errors++;
          $display("%0t: energy_sum expected %h actual %h", $time, w.e, energy_sum);
        end
        if (force_x !== w.fx) begin
          errors++;
          $display("%0t: force_x expected %h actual %h", $time, w.fx, force_x);
        end
        if (force_y !== w.fy) begin
          errors++;
          $display("%0t: force_y expected %h actual %h", $time, w.fy, force_y);
        end
        if (force_z !== w.fz) begin
          errors++;
          $display("%0t: force_z expected %h actual %h", $time, w.fz, force_z);
        end
        if (saturated !== w.sat) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, w.sat, saturated);
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    row_t rows [$];
    row_t rw;
    item_t it;
    sums_t none;
    sums_t zero_sat;
    sums_t zero_clean;
    none = '{0, 0, 0, 0, 0};
    zero_sat = '{0, 0, 0, 0, 1};
    zero_clean = '{0, 0, 0, 0, 0};
    energy_run = 0;
    force_run[0] = 0; force_run[1] = 0; force_run[2] = 0;
    sat_run = 0;
    for (int a = 0; a < NTYPES; a++)
      for (int b = a; b < NTYPES; b++)
        rows.push_back('{write_item(a, b, 32'h0100_0000, 32'h0100_0000, 32'h0280_0000),
                         0, none});
    rows.push_back('{write_item(3, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, none});
    rows.push_back('{write_item(0, 0, 32'h0100_0000, 32'h0100_0000, 32'h0), 0, none});
    rows.push_back('{write_item(2, 1, 32'h0, 32'h0200_0000, 32'h0300_0000), 0, none});
    rows.push_back('{pair_item(1, 1, 0, 0, 0, 1, 1), 1, zero_sat});
    rows.push_back('{pair_item(0, 0, 32'h0100_0000, 0, 0, 1, 1), 1, zero_clean});
    rows.push_back('{pair_item(1, 3, 32'h0100_0000, 0, 0, 1, 1), 0, none});
    rows.push_back('{pair_item(0, 1, 32'h0080_0000, 32'hFF80_0000, 32'h0040_0000, 1, 0), 0, none});
    rows.push_back('{pair_item(1, 0, 32'h0120_0000, 0, 32'hFF00_0000, 0, 0), 0, none});
    rows.push_back('{pair_item(2, 2, 32'h0002_0000, 0, 0, 1, 1), 0, none});
    rows.push_back('{pair_item(3, 3, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1, 1), 0, none});
    rows.push_back('{pair_item(3, 3, 32'h0000_0001, 0, 0, 1, 1), 0, none});
    rows.push_back('{pair_item(1, 2, 32'h0100_0000, 32'h0100_0000, 0, 1, 1), 0, none});
    rows.push_back('{pair_item(3, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1),
                     1, zero_clean});
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);
    for (int n = 0; n < 1830; n++) begin
      calm = (n >= 600 && n < 900);
      if (n == 1000) begin
        in_valid <= 0;
        wait (pending_sums.size() == 0);
        @(posedge clk);
      end
      if ($urandom_range(99) < 7) begin
        case ($urandom_range(3))
          0: it = write_item($urandom, $urandom, $urandom, $urandom, $urandom);
          1: it = write_item($urandom, $urandom, $urandom_range(32'h0200_0000, 32'h0080_0000),
                             $urandom_range(32'h0400_0000), 0);
          default: it = write_item($urandom, $urandom,
                                   $urandom_range(32'h0200_0000, 32'h0080_0000),
                                   $urandom_range(32'h0400_0000),
                                   $urandom_range(32'h0400_0000, 32'h0100_0000));
        endcase
      end else begin
        it = pair_item($urandom, $urandom, rand_axis(), rand_axis(), rand_axis(),
                       $urandom_range(3) != 0, $urandom_range(7) == 0);
      end
      send_item(it, 0, none);
    end
    in_valid <= 0;
    wait (pending_sums.size() == 0);
    repeat (400) @(posedge clk);
    $display("run: %0d items sent (%0d table writes), %0d accumulated sums checked",
             n_items, n_writes, n_sums);
    if (errors == 0 && pending_sums.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ljpe_pkg.sv
hw/rtl/ljpe_ram.sv
hw/rtl/ljpe_ctrl.sv
hw/rtl/ljpe_dp.sv
hw/rtl/lj_pair_energy_force_accumulator.sv
tb/testbench.sv
